// ===== rtl/aaca_pkg.sv =====
// ----------------------------------------------------------------------------
// aaca_pkg: shared definitions for the axis alignment cost accumulator
// Field widths, register indexes, reset values and divider geometry.
// ----------------------------------------------------------------------------
package aaca_pkg;

    // Payload widths
    localparam int VEL_W   = 16;
    localparam int PLEN_W  = 16;
    localparam int COST_W  = 32;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int POWER_W    = 4;
    localparam int WEIGHT_W   = 16;
    localparam int THR_W      = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLONOMIC = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NORMALIZE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_POWER     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 3'd5;

    localparam logic                RST_ENABLE    = 1'b1;
    localparam logic                RST_HOLONOMIC = 1'b1;
    localparam logic                RST_NORMALIZE = 1'b1;
    localparam logic [POWER_W-1:0]  RST_POWER     = 4'd1;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT    = 16'd768;   // 3.0 in Q8.8
    localparam logic [THR_W-1:0]    RST_THRESHOLD = 16'd128;   // 0.5 in Q8.8

    // Accumulator
    localparam int SUM_W = 28;

    // Top-level parameter defaults
    localparam int MAX_STEPS_DEF     = 64;
    localparam int VEL_FRAC_BITS_DEF = 10;

    // Shared divider: 32-bit dividend, 16-bit divisor, two quotient bits a cycle
    localparam int DIV_W      = 32;
    localparam int DVS_W      = 16;
    localparam int DIV_STEP   = 2;
    localparam int DIV_CYCLES = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    typedef struct packed {
        logic busy;
        logic done;    // last iteration cycle; quotient valid after this edge
    } t_div_stat;

endpackage

// ===== rtl/aaca_if.sv =====
// ----------------------------------------------------------------------------
// aaca channel interfaces
// Sample input, cost output and configuration write channels.
// ----------------------------------------------------------------------------
interface aaca_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [aaca_pkg::VEL_W-1:0] vel_x;
    logic signed [aaca_pkg::VEL_W-1:0] vel_y;
    logic [aaca_pkg::PLEN_W-1:0]       path_length;
    logic [aaca_pkg::COST_W-1:0]       prior_cost;
    logic                              last_sample;

    modport source (output valid, vel_x, vel_y, path_length, prior_cost, last_sample,
                    input ready);
    modport sink   (input valid, vel_x, vel_y, path_length, prior_cost, last_sample,
                    output ready);
endinterface

interface aaca_out_if;
    logic                        valid;
    logic                        ready;
    logic [aaca_pkg::COST_W-1:0] total_cost;
    logic                        saturated;

    modport source (output valid, total_cost, saturated, input ready);
    modport sink   (input valid, total_cost, saturated, output ready);
endinterface

interface aaca_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [aaca_pkg::CFG_ADDR_W-1:0] addr;
    logic [aaca_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ===== rtl/aaca_div.sv =====
// ----------------------------------------------------------------------------
// aaca_div: iterative unsigned divider
// Restoring division, two quotient bits per cycle, shared by the per-sample
// ratio and the final mean.
// ----------------------------------------------------------------------------
module aaca_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [aaca_pkg::DIV_W-1:0]   i_dividend,
    input  logic [aaca_pkg::DVS_W-1:0]   i_divisor,
    output aaca_pkg::t_div_stat          o_stat,
    output logic [aaca_pkg::DIV_W-1:0]   o_quotient
);

    logic                              r_busy;
    logic [aaca_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [aaca_pkg::DVS_W-1:0]        r_dvs;
    logic [aaca_pkg::DVS_W-1:0]        r_rem;
    logic [aaca_pkg::DIV_W-1:0]        r_dq;     // dividend shifts out, quotient in
    logic [aaca_pkg::DVS_W-1:0]        n_rem;
    logic [aaca_pkg::DIV_W-1:0]        n_dq;

    always_comb begin
        logic [aaca_pkg::DVS_W:0] v_sh;
        n_rem = r_rem;
        n_dq  = r_dq;
        for (int k = 0; k < aaca_pkg::DIV_STEP; k++) begin
            v_sh = {n_rem, n_dq[aaca_pkg::DIV_W-1]};
            n_dq = {n_dq[aaca_pkg::DIV_W-2:0], 1'b0};
            if (v_sh >= {1'b0, r_dvs}) begin
                n_rem   = aaca_pkg::DVS_W'(v_sh - {1'b0, r_dvs});
                n_dq[0] = 1'b1;
            end else begin
                n_rem = v_sh[aaca_pkg::DVS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= aaca_pkg::DIV_CNT_W'(aaca_pkg::DIV_CYCLES - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_dq  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dq  <= n_dq;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == '0);
    assign o_quotient  = r_dq;

endmodule

// ===== rtl/axis_alignment_cost_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// axis_alignment_cost_accumulator_core
// Scores one trajectory from a stream of velocity samples and adds the
// weighted, optionally powered mean alignment term to the prior cost.
// ----------------------------------------------------------------------------
// Channels: i_in takes one velocity sample per transfer; the transfer with
// last_sample set closes the trajectory and produces one transfer on o_out
// (total_cost, saturated). Other samples produce nothing. i_cfg writes the
// six registers by index and is always ready; write it only while idle.
// Per sample, ratio mode runs the shared two-bit-per-cycle divider before the
//   accumulate step; absolute mode, and every sample once the step cap is
//   reached, goes straight to the accumulate step.
// The last sample then passes the gate check, the mean division, the weight
//   multiply and clip, power-1 multiply-and-clip rounds when the power register
//   is above 1, and the final sum; only the gate check when the cost is gated
//   off. The final step loads the result into the output register.
// One item is in work at a time; i_in.ready is high only when the sequencer
// is idle. The output register lets the next trajectory start while a result
// waits; if a new result is due while it is still held, the sequencer waits.
// Reset (synchronous, active low) clears the sum and count, empties the
// output register and returns the registers to their documented defaults.
// ----------------------------------------------------------------------------
module axis_alignment_cost_accumulator_core #(
    parameter int MAX_STEPS     = aaca_pkg::MAX_STEPS_DEF,
    parameter int VEL_FRAC_BITS = aaca_pkg::VEL_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aaca_in_if.sink    i_in,
    aaca_cfg_if.sink   i_cfg,
    aaca_out_if.source o_out
);

    localparam int CntW       = $clog2(MAX_STEPS + 1);
    localparam int AbsShift   = 16 - VEL_FRAC_BITS;
    localparam int TermW      = (32 - VEL_FRAC_BITS > 17) ? 32 - VEL_FRAC_BITS : 17;
    localparam int FloorRaw   = ((1 << VEL_FRAC_BITS) + 500) / 1000;
    localparam int VelFloor   = (FloorRaw == 0) ? 1 : FloorRaw;
    localparam int ProdW      = 2 * aaca_pkg::COST_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DIV   = 10'b0000000010,
        S_ACC   = 10'b0000000100,
        S_FIN   = 10'b0000001000,
        S_MEAN  = 10'b0000010000,
        S_WMUL  = 10'b0000100000,
        S_WCLIP = 10'b0001000000,
        S_PMUL  = 10'b0010000000,
        S_PCLIP = 10'b0100000000,
        S_SUM   = 10'b1000000000
    } t_state;

    // Configuration
    logic                           r_enable;
    logic                           r_holo;
    logic                           r_norm;
    logic [aaca_pkg::POWER_W-1:0]   r_power;
    logic [aaca_pkg::WEIGHT_W-1:0]  r_weight;
    logic [aaca_pkg::THR_W-1:0]     r_thr;

    // Sequencer and state
    t_state                         r_state, n_state;
    logic [aaca_pkg::SUM_W-1:0]     r_sum;
    logic [CntW-1:0]                r_count;
    logic                           r_last, r_add, r_ratio;
    logic [aaca_pkg::PLEN_W-1:0]    r_plen;
    logic [aaca_pkg::COST_W-1:0]    r_prior;
    logic [TermW-1:0]               r_term;
    logic [ProdW-1:0]               r_prod;
    logic [aaca_pkg::COST_W-1:0]    r_x, r_r;
    logic [aaca_pkg::POWER_W-1:0]   r_pcnt;
    logic                           r_sat;

    // Output register
    logic                           r_out_valid;
    logic [aaca_pkg::COST_W-1:0]    r_out_cost;
    logic                           r_out_sat;

    // Sample front end
    logic [aaca_pkg::VEL_W-1:0]     mag_x, mag_y, lo, hi, hi_fl;
    logic                           in_xfer, cfg_xfer, add_ok;

    // Shared units
    logic                           div_start;
    logic [aaca_pkg::DIV_W-1:0]     div_dividend, div_q;
    logic [aaca_pkg::DVS_W-1:0]     div_divisor;
    aaca_pkg::t_div_stat            div_stat;
    logic [aaca_pkg::COST_W-1:0]    mul_a, mul_b;
    logic [ProdW-1:0]               mul_p;

    // Datapath helpers
    logic [TermW-1:0]               term;
    logic [aaca_pkg::SUM_W:0]       sum_wide;
    logic                           gate, out_free, out_load;
    logic [aaca_pkg::COST_W:0]      total_wide;
    logic [aaca_pkg::COST_W-1:0]    x_clip, r_step_clip;
    logic                           x_ovf, step_ovf;
    logic [aaca_pkg::COST_W-1:0]    out_cost;
    logic                           out_sat;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign cfg_xfer = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= aaca_pkg::RST_ENABLE;
            r_holo   <= aaca_pkg::RST_HOLONOMIC;
            r_norm   <= aaca_pkg::RST_NORMALIZE;
            r_power  <= aaca_pkg::RST_POWER;
            r_weight <= aaca_pkg::RST_WEIGHT;
            r_thr    <= aaca_pkg::RST_THRESHOLD;
        end else if (cfg_xfer) begin
            case (i_cfg.addr)
                aaca_pkg::REG_ENABLE:    r_enable <= i_cfg.data[0];
                aaca_pkg::REG_HOLONOMIC: r_holo   <= i_cfg.data[0];
                aaca_pkg::REG_NORMALIZE: r_norm   <= i_cfg.data[0];
                aaca_pkg::REG_POWER:     r_power  <= i_cfg.data[aaca_pkg::POWER_W-1:0];
                aaca_pkg::REG_WEIGHT:    r_weight <= i_cfg.data[aaca_pkg::WEIGHT_W-1:0];
                aaca_pkg::REG_THRESHOLD: r_thr    <= i_cfg.data[aaca_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sample magnitudes; -32768 maps to 32768 in 16 unsigned bits
    // ------------------------------------------------------------------------
    assign mag_x  = i_in.vel_x[aaca_pkg::VEL_W-1] ? (~i_in.vel_x + 1'b1) : i_in.vel_x;
    assign mag_y  = i_in.vel_y[aaca_pkg::VEL_W-1] ? (~i_in.vel_y + 1'b1) : i_in.vel_y;
    assign lo     = (mag_x < mag_y) ? mag_x : mag_y;
    assign hi     = (mag_x < mag_y) ? mag_y : mag_x;
    assign hi_fl  = (hi < aaca_pkg::VEL_W'(VelFloor)) ? aaca_pkg::VEL_W'(VelFloor) : hi;
    assign add_ok = (r_count < CntW'(MAX_STEPS));

    // ------------------------------------------------------------------------
    // Shared divider: ratio term at sample time, mean at the end
    // ------------------------------------------------------------------------
    assign gate = r_enable && r_holo && (r_plen >= r_thr) && (r_count != '0);

    always_comb begin
        div_start    = 1'b0;
        div_dividend = {lo, 16'd0};
        div_divisor  = hi_fl;
        if (r_state == S_FIN) begin
            div_dividend = aaca_pkg::DIV_W'(r_sum);
            div_divisor  = aaca_pkg::DVS_W'(r_count);
            div_start    = gate;
        end else begin
            div_start    = in_xfer && add_ok && r_norm;
        end
    end

    aaca_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_q)
    );

    // ------------------------------------------------------------------------
    // Shared multiplier, product registered
    // ------------------------------------------------------------------------
    assign mul_a = (r_state == S_PMUL) ? r_r : div_q;
    assign mul_b = (r_state == S_PMUL) ? r_x : aaca_pkg::COST_W'(r_weight);
    assign mul_p = mul_a * mul_b;

    assign x_ovf       = (r_prod[ProdW-1:aaca_pkg::COST_W+8] != '0);
    assign x_clip      = x_ovf ? '1 : r_prod[aaca_pkg::COST_W+7:8];
    assign step_ovf    = (r_prod[ProdW-1:aaca_pkg::COST_W+16] != '0);
    assign r_step_clip = step_ovf ? '1 : r_prod[aaca_pkg::COST_W+15:16];

    // ------------------------------------------------------------------------
    // Accumulate
    // ------------------------------------------------------------------------
    assign term     = r_ratio ? div_q[TermW-1:0] : r_term;
    assign sum_wide = {1'b0, r_sum} + (aaca_pkg::SUM_W + 1)'(term);

    assign total_wide = {1'b0, r_prior} + {1'b0, r_r};
    assign out_free   = !r_out_valid || o_out.ready;

    always_comb begin
        out_load = 1'b0;
        out_cost = r_prior;
        out_sat  = 1'b0;
        if (r_state == S_FIN && !gate && out_free) begin
            out_load = 1'b1;
        end else if (r_state == S_SUM && out_free) begin
            out_load = 1'b1;
            out_cost = total_wide[aaca_pkg::COST_W] ? '1 : total_wide[aaca_pkg::COST_W-1:0];
            out_sat  = r_sat || total_wide[aaca_pkg::COST_W];
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = (add_ok && r_norm) ? S_DIV : S_ACC;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC:   n_state = r_last ? S_FIN : S_IDLE;
            S_FIN: begin
                if (gate) begin
                    n_state = S_MEAN;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_MEAN: begin
                if (div_stat.done) begin
                    n_state = S_WMUL;
                end
            end
            S_WMUL:  n_state = S_WCLIP;
            S_WCLIP: n_state = (r_power > aaca_pkg::POWER_W'(1)) ? S_PMUL : S_SUM;
            S_PMUL:  n_state = S_PCLIP;
            S_PCLIP: n_state = (r_pcnt == aaca_pkg::POWER_W'(1)) ? S_SUM : S_PMUL;
            S_SUM: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ACC && r_add) begin
                r_sum   <= sum_wide[aaca_pkg::SUM_W] ? '1 : sum_wide[aaca_pkg::SUM_W-1:0];
                r_count <= r_count + 1'b1;
            end else if (out_load) begin
                r_sum   <= '0;
                r_count <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_last  <= i_in.last_sample;
            r_plen  <= i_in.path_length;
            r_prior <= i_in.prior_cost;
            r_add   <= add_ok;
            r_ratio <= r_norm;
            r_term  <= TermW'(lo) << AbsShift;
        end
        if (r_state == S_WMUL || r_state == S_PMUL) begin
            r_prod <= mul_p;
        end
        if (r_state == S_FIN) begin
            r_sat <= 1'b0;
        end else if (r_state == S_WCLIP) begin
            r_x    <= x_clip;
            r_r    <= x_clip;
            r_sat  <= x_ovf;
            r_pcnt <= r_power - 1'b1;
        end else if (r_state == S_PCLIP) begin
            r_r    <= r_step_clip;
            r_sat  <= r_sat || step_ovf;
            r_pcnt <= r_pcnt - 1'b1;
        end
        if (out_load) begin
            r_out_cost <= out_cost;
            r_out_sat  <= out_sat;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.total_cost = r_out_cost;
    assign o_out.saturated  = r_out_sat;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MAX_STEPS))
        else $error("sample count above limit");

    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_sum == '0 && r_count == '0 && r_out_valid))
        else $error("state not cleared after result");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && r_ratio && r_add) |-> (div_q <= aaca_pkg::DIV_W'(65536)))
        else $error("ratio term above one");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for axis_alignment_cost_accumulator_core
// Drives velocity samples and register writes, predicts each trajectory score
// in the bench or takes it from the directed table, and compares each output transfer against it in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int VEL_FRAC    = aaca_pkg::VEL_FRAC_BITS_DEF;
    localparam int STEP_CAP    = aaca_pkg::MAX_STEPS_DEF;
    localparam int FLOOR_RAW   = ((1 << VEL_FRAC) + 500) / 1000;
    localparam int SPEED_FLOOR = (FLOOR_RAW == 0) ? 1 : FLOOR_RAW;
    localparam logic [aaca_pkg::SUM_W-1:0] SUM_CAP = '1;

    localparam int RAND_ITEMS   = 600;
    localparam int DRAIN_CYCLES = 64;     // longest non-last sample plus margin
    localparam int HOLD_CYCLES  = 500;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DIR_ROWS     = 23;

    typedef enum logic {ROW_SMP, ROW_CFG} t_row_kind;

    typedef struct {
        logic signed [aaca_pkg::VEL_W-1:0] vx;
        logic signed [aaca_pkg::VEL_W-1:0] vy;
        logic [aaca_pkg::PLEN_W-1:0]       plen;
        logic [aaca_pkg::COST_W-1:0]       prior;
        logic                              last;
    } t_sample;

    typedef struct {
        logic [aaca_pkg::COST_W-1:0] total;
        logic                        sat;
    } t_cost;

    typedef struct {
        t_row_kind                       kind;
        logic [aaca_pkg::CFG_ADDR_W-1:0] addr;
        int                              data;
        int                              vx;
        int                              vy;
        int                              plen;
        logic [aaca_pkg::COST_W-1:0]     prior;
        bit                              last;
        bit                              typed;
        logic [aaca_pkg::COST_W-1:0]     exp_total;
        bit                              exp_sat;
    } t_dir_row;

    // Opening sequence: reset defaults, saturation, gating, mode/power/weight corners
    t_dir_row opening_rows [DIR_ROWS] = '{
        '{ROW_SMP, aaca_pkg::REG_ENABLE, 0,
          0, 0, 128, 32'h0000_0000, 1, 1, 32'h0000_0000, 0},
        '{ROW_SMP, aaca_pkg::REG_ENABLE, 0,
          1024, 1024, 128, 32'h0001_0000, 1, 1, 32'h0004_0000, 0},
        '{ROW_SMP, aaca_pkg::REG_ENABLE, 0,
          -32768, -32768, 128, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 1},
        '{ROW_SMP, aaca_pkg::REG_ENABLE, 0,
          32767, 0, 127, 32'h1234_5678, 1, 1, 32'h1234_5678, 0},
        '{ROW_SMP, aaca_pkg::REG_ENABLE, 0,
          32767, -32768, 200, 32'h0000_0000, 0, 0, 32'h0, 0},
        '{ROW_SMP, aaca_pkg::REG_ENABLE, 0,
          -1, 1, 200, 32'h0000_8000, 1, 0, 32'h0, 0},
        '{ROW_CFG, aaca_pkg::REG_ENABLE, 0,
          0, 0, 0, 32'h0, 0, 0, 32'h0, 0},
        '{ROW_SMP, aaca_pkg::REG_ENABLE, 0,
          500, 300, 65535, 32'hABCD_0000, 1, 1, 32'hABCD_0000, 0},
        '{ROW_CFG, aaca_pkg::REG_ENABLE, 1,
          0, 0, 0, 32'h0, 0, 0, 32'h0, 0},
        '{ROW_CFG, aaca_pkg::REG_HOLONOMIC, 0,
          0, 0, 0, 32'h0, 0, 0, 32'h0, 0},
        '{ROW_SMP, aaca_pkg::REG_ENABLE, 0,
          100, -200, 65535, 32'h0000_0001, 1, 1, 32'h0000_0001, 0},
        '{ROW_CFG, aaca_pkg::REG_HOLONOMIC, 1,
          0, 0, 0, 32'h0, 0, 0, 32'h0, 0},
        '{ROW_CFG, aaca_pkg::REG_NORMALIZE, 0,
          0, 0, 0, 32'h0, 0, 0, 32'h0, 0},
        '{ROW_CFG, aaca_pkg::REG_THRESHOLD, 0,
          0, 0, 0, 32'h0, 0, 0, 32'h0, 0},
        '{ROW_SMP, aaca_pkg::REG_ENABLE, 0,
          -32768, 32767, 0, 32'h0000_0000, 1, 0, 32'h0, 0},
        '{ROW_CFG, aaca_pkg::REG_POWER, 15,
          0, 0, 0, 32'h0, 0, 0, 32'h0, 0},
        '{ROW_CFG, aaca_pkg::REG_WEIGHT, 65535,
          0, 0, 0, 32'h0, 0, 0, 32'h0, 0},
        '{ROW_SMP, aaca_pkg::REG_ENABLE, 0,
          32767, -32768, 0, 32'h0000_0000, 0, 0, 32'h0, 0},
        '{ROW_SMP, aaca_pkg::REG_ENABLE, 0,
          20000, -5, 0, 32'h0000_0100, 1, 0, 32'h0, 0},
        '{ROW_CFG, aaca_pkg::REG_POWER, 0,
          0, 0, 0, 32'h0, 0, 0, 32'h0, 0},
        '{ROW_SMP, aaca_pkg::REG_ENABLE, 0,
          1, 1, 0, 32'h0000_0007, 1, 0, 32'h0, 0},
        '{ROW_CFG, aaca_pkg::REG_WEIGHT, 0,
          0, 0, 0, 32'h0, 0, 0, 32'h0, 0},
        '{ROW_SMP, aaca_pkg::REG_ENABLE, 0,
          -77, 12345, 0, 32'h00C0_FFEE, 1, 1, 32'h00C0_FFEE, 0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    aaca_in_if  in_ch ();
    aaca_out_if out_ch ();
    aaca_cfg_if cfg_ch ();

    axis_alignment_cost_accumulator_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Register mirror and trajectory state of the predictor
    logic                            cfg_en    = aaca_pkg::RST_ENABLE;
    logic                            cfg_hol   = aaca_pkg::RST_HOLONOMIC;
    logic                            cfg_norm  = aaca_pkg::RST_NORMALIZE;
    logic [aaca_pkg::POWER_W-1:0]    cfg_pow   = aaca_pkg::RST_POWER;
    logic [aaca_pkg::WEIGHT_W-1:0]   cfg_wgt   = aaca_pkg::RST_WEIGHT;
    logic [aaca_pkg::THR_W-1:0]      cfg_thr   = aaca_pkg::RST_THRESHOLD;
    logic [aaca_pkg::SUM_W-1:0]      trk_sum   = '0;
    logic [10:0]                     trk_count = '0;

    t_cost cost_due [$];
    int    mismatch_count = 0;
    int    quiet_cycles = 0;
    bit    hold_long = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got 0x%08h expected 0x%08h at %0t",
                 what, got, want, $time);
        mismatch_count++;
    endtask

    function automatic logic [aaca_pkg::SUM_W-1:0] axis_term(
            input logic signed [aaca_pkg::VEL_W-1:0] vx,
            input logic signed [aaca_pkg::VEL_W-1:0] vy,
            input logic norm);
        int          mag_x;
        int          mag_y;
        int          lo;
        int          hi;
        logic [47:0] num;
        mag_x = (vx < 0) ? -int'(vx) : int'(vx);
        mag_y = (vy < 0) ? -int'(vy) : int'(vy);
        lo = (mag_x < mag_y) ? mag_x : mag_y;
        hi = (mag_x < mag_y) ? mag_y : mag_x;
        if (norm) begin
            if (hi < SPEED_FLOOR)
                hi = SPEED_FLOOR;
            num = 48'(lo) << 16;
            return aaca_pkg::SUM_W'(num / 48'(hi));
        end
        return aaca_pkg::SUM_W'(lo) << (16 - VEL_FRAC);
    endfunction

    // {clipped, value}
    function automatic logic [32:0] clip32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? {1'b1, 32'hFFFF_FFFF} : {1'b0, v[31:0]};
    endfunction

    task automatic score_sample(input t_sample s, output bit has_cost, output t_cost c);
        logic [63:0] acc;
        logic [63:0] mean;
        logic [63:0] x;
        logic [63:0] r;
        logic [32:0] clipped;
        bit          sat;
        int          k;
        // samples past the step cap are dropped, a last one included
        if (trk_count < STEP_CAP) begin
            acc = 64'(trk_sum) + 64'(axis_term(s.vx, s.vy, cfg_norm));
            trk_sum = (acc > 64'(SUM_CAP)) ? SUM_CAP : acc[aaca_pkg::SUM_W-1:0];
            trk_count++;
        end
        has_cost = s.last;
        c.total = s.prior;
        c.sat = 1'b0;
        if (s.last) begin
            sat = 1'b0;
            if (cfg_en && cfg_hol && s.plen >= cfg_thr && trk_count != 0) begin
                mean = 64'(trk_sum) / 64'(trk_count);
                clipped = clip32((mean * 64'(cfg_wgt)) >> 8);
                sat |= clipped[32];
                x = 64'(clipped[31:0]);
                r = x;
                for (k = 1; k < int'(cfg_pow); k++) begin
                    clipped = clip32((r * x) >> 16);
                    sat |= clipped[32];
                    r = 64'(clipped[31:0]);
                end
                clipped = clip32(64'(s.prior) + r);
                sat |= clipped[32];
                c.total = clipped[31:0];
            end
            c.sat = sat;
            trk_sum = '0;
            trk_count = '0;
        end
    endtask

    task automatic write_reg(input logic [aaca_pkg::CFG_ADDR_W-1:0] addr, input int data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.addr  = addr;
        cfg_ch.data  = aaca_pkg::CFG_DATA_W'(data);
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (addr)
            aaca_pkg::REG_ENABLE:    cfg_en   = cfg_ch.data[0];
            aaca_pkg::REG_HOLONOMIC: cfg_hol  = cfg_ch.data[0];
            aaca_pkg::REG_NORMALIZE: cfg_norm = cfg_ch.data[0];
            aaca_pkg::REG_POWER:     cfg_pow  = cfg_ch.data[aaca_pkg::POWER_W-1:0];
            aaca_pkg::REG_WEIGHT:    cfg_wgt  = cfg_ch.data[aaca_pkg::WEIGHT_W-1:0];
            aaca_pkg::REG_THRESHOLD: cfg_thr  = cfg_ch.data[aaca_pkg::THR_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Returns with the sample accepted; the predictor is updated at that edge.
    task automatic send_sample(input t_sample s, input int gap, input bit typed,
                               input t_cost typed_cost);
        bit    has_cost;
        t_cost c;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.vel_x       = s.vx;
        in_ch.vel_y       = s.vy;
        in_ch.path_length = s.plen;
        in_ch.prior_cost  = s.prior;
        in_ch.last_sample = s.last;
        in_ch.valid       = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        score_sample(s, has_cost, c);
        if (has_cost)
            cost_due.push_back(typed ? typed_cost : c);
    endtask

    // Block idle: nothing owed, and any non-last sample in work has finished
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (cost_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [aaca_pkg::VEL_W-1:0] draw_vel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            2: return aaca_pkg::VEL_W'($urandom_range(0, 8) - 4);
            3: return aaca_pkg::VEL_W'($urandom_range(0, 4094) - 2047);
            default: return aaca_pkg::VEL_W'($urandom);
        endcase
    endfunction

    initial begin : sample_source
        t_sample s;
        t_cost   typed_cost;
        int      sent;
        int      ph;
        int      n_traj;
        int      len;
        bit      burst;
        in_ch.valid       = 1'b0;
        in_ch.vel_x       = '0;
        in_ch.vel_y       = '0;
        in_ch.path_length = '0;
        in_ch.prior_cost  = '0;
        in_ch.last_sample = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.addr       = '0;
        cfg_ch.data       = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (opening_rows[i]) begin
            if (opening_rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(opening_rows[i].addr, opening_rows[i].data);
            end else begin
                s.vx    = aaca_pkg::VEL_W'(opening_rows[i].vx);
                s.vy    = aaca_pkg::VEL_W'(opening_rows[i].vy);
                s.plen  = aaca_pkg::PLEN_W'(opening_rows[i].plen);
                s.prior = opening_rows[i].prior;
                s.last  = opening_rows[i].last;
                typed_cost.total = opening_rows[i].exp_total;
                typed_cost.sat   = opening_rows[i].exp_sat;
                send_sample(s, $urandom_range(0, 7), opening_rows[i].typed, typed_cost);
            end
        end

        sent = 0;
        ph = 0;
        while (sent < RAND_ITEMS) begin
            settle();
            write_reg(aaca_pkg::REG_ENABLE, (ph == 0) || ($urandom_range(0, 9) != 0));
            write_reg(aaca_pkg::REG_HOLONOMIC, (ph == 0) || ($urandom_range(0, 9) != 0));
            write_reg(aaca_pkg::REG_NORMALIZE, $urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0: write_reg(aaca_pkg::REG_POWER, 0);
                1: write_reg(aaca_pkg::REG_POWER, 1);
                2: write_reg(aaca_pkg::REG_POWER, 8);
                3: write_reg(aaca_pkg::REG_POWER, 15);
                default: write_reg(aaca_pkg::REG_POWER, $urandom_range(2, 4));
            endcase
            case ($urandom_range(0, 4))
                0: write_reg(aaca_pkg::REG_WEIGHT, 0);
                1: write_reg(aaca_pkg::REG_WEIGHT, 65535);
                2: write_reg(aaca_pkg::REG_WEIGHT, $urandom_range(0, 65535));
                default: write_reg(aaca_pkg::REG_WEIGHT, $urandom_range(64, 1024));
            endcase
            if (ph == 0)
                write_reg(aaca_pkg::REG_THRESHOLD, 0);
            else if (ph % 5 == 4)
                write_reg(aaca_pkg::REG_THRESHOLD, 65535);
            else
                write_reg(aaca_pkg::REG_THRESHOLD,
                          $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 512));

            // Phase 2 parks the output side while short trajectories stream in
            burst = (ph == 2) || ($urandom_range(0, 3) == 0);
            if (ph == 2)
                hold_long = 1'b1;
            n_traj = $urandom_range(6, 12);
            for (int t = 0; t < n_traj; t++) begin
                if (ph == 0 && t == 0)
                    len = 70;
                else if (ph == 2)
                    len = $urandom_range(1, 2);
                else if ($urandom_range(0, 11) == 0)
                    len = $urandom_range(60, 80);
                else
                    len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    s.vx = draw_vel();
                    s.vy = draw_vel();
                    case ($urandom_range(0, 5))
                        0: s.plen = cfg_thr;
                        1: s.plen = cfg_thr - 1'b1;
                        2: s.plen = '0;
                        3: s.plen = '1;
                        default: s.plen = aaca_pkg::PLEN_W'($urandom);
                    endcase
                    case ($urandom_range(0, 3))
                        0: s.prior = {16'hFFFF, 16'($urandom)};
                        1: s.prior = '0;
                        default: s.prior = $urandom;
                    endcase
                    s.last = (i == len - 1);
                    send_sample(s, burst ? 0 : $urandom_range(0, 7), 1'b0, typed_cost);
                    sent++;
                end
            end
            ph++;
        end

        settle();
        if (mismatch_count == 0) begin
            $display("axis_alignment_cost_accumulator_core regression: pass");
        end else begin
            $display("axis_alignment_cost_accumulator_core regression: fail");
        end
        $finish;
    end

    initial begin : cost_sink
        int    stall;
        int    run_left;
        bit    stall_mode;
        t_cost want;
        out_ch.ready = 1'b0;
        run_left = 0;
        stall_mode = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_long = 1'b0;
            end
            // alternate stretches of random stalls with stretches of none
            if (run_left == 0) begin
                stall_mode = $urandom_range(0, 1);
                run_left = $urandom_range(1, 24);
            end
            run_left--;
            stall = stall_mode ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            if (cost_due.size() == 0) begin
                report_mismatch("transfer with no score owed", out_ch.total_cost, '0);
            end else begin
                want = cost_due.pop_front();
                if (out_ch.total_cost !== want.total)
                    report_mismatch("total_cost", out_ch.total_cost, want.total);
                if (out_ch.saturated !== want.sat)
                    report_mismatch("saturated", 32'(out_ch.saturated), 32'(want.sat));
            end
        end
    end

    // Watchdog: cycles without any transfer on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("axis_alignment_cost_accumulator_core regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== filelist.f =====
rtl/aaca_pkg.sv
rtl/aaca_if.sv
rtl/aaca_div.sv
rtl/axis_alignment_cost_accumulator_core.sv
sim/tb_top.sv
